// ===== src/rc6_biphase_ir_decoder_unit_defines.svh =====
`ifndef RC6_BIPHASE_IR_DECODER_UNIT_DEFINES_SVH
`define RC6_BIPHASE_IR_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RC6BP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define RC6BP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rc6bp_pkg.sv =====
package rc6bp_pkg;

    localparam int FRAME_BITS      = 21;
    localparam int TOGGLE_POSITION = 4;
    localparam int ADDRESS_SHIFT   = 8;
    localparam int ADDRESS_BITS    = 8;
    localparam int COMMAND_BITS    = 8;
    localparam int MAX_DURATIONS   = 64;

    localparam int DUR_W     = 15;
    localparam int UNIT_W    = 12;
    localparam int TOL_W     = 7;
    localparam int BIT_IDX_W = $clog2(FRAME_BITS + 1);
    localparam int DCOUNT_W  = $clog2(MAX_DURATIONS + 2);
    localparam int HALF_W    = 3;
    localparam int NUM_W     = DUR_W + 1;
    localparam int DCNT_W    = $clog2(NUM_W + 1);
    localparam int PROD_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PCT_FULL  = 100;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_HEADER  = 2'd1,
        ST_BAD_BIPHASE = 2'd2,
        ST_FEW_BITS    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_LENGTH  = 3'd0,
        CFG_HEADER_MARK  = 3'd1,
        CFG_HEADER_SPACE = 3'd2,
        CFG_TOLERANCE    = 3'd3,
        CFG_MIN_BITS     = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HMUL,
        S_HCMP,
        S_PICK,
        S_DIV,
        S_UNIT,
        S_END,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic hmul;
        logic hcmp;
        logic div_start;
        logic div_step;
        logic unit_step;
        logic emit;
        logic sel;
    } t_dp_cmd;

    typedef struct packed {
        logic header_seen;
        logic hdr_bad;
        logic list_full;
        logic mark_nonzero;
        logic space_nonzero;
        logic div_done;
        logic units_zero;
        logic stopped;
        logic frame_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/rc6bp_ctrl.sv =====
module rc6bp_ctrl
    import rc6bp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = 1'b0;
                    if (!i_stat.header_seen) begin
                        n_state = S_HMUL;
                    end else if (!i_stat.hdr_bad && !i_stat.list_full) begin
                        n_state = S_PICK;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state    = S_HCMP;
            end
            S_HCMP: begin
                o_cmd.hcmp = 1'b1;
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = S_HMUL;
                end else begin
                    n_state = S_END;
                end
            end
            S_PICK: begin
                if ((!r_sel && i_stat.mark_nonzero) || (r_sel && i_stat.space_nonzero)) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (!r_sel) begin
                    n_sel = 1'b1;
                end else begin
                    n_state = S_END;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_UNIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_UNIT: begin
                if (i_stat.units_zero || i_stat.stopped) begin
                    if (!r_sel) begin
                        n_sel   = 1'b1;
                        n_state = S_PICK;
                    end else begin
                        n_state = S_END;
                    end
                end else begin
                    o_cmd.unit_step = 1'b1;
                end
            end
            S_END: begin
                n_state = i_stat.frame_end ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rc6bp_datapath.sv =====
module rc6bp_datapath
    import rc6bp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [DUR_W-1:0]        i_mark_duration,
    input  logic [DUR_W-1:0]        i_space_duration,
    input  logic                    i_frame_end,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [1:0]              o_status,
    output logic [ADDRESS_BITS-1:0] o_address,
    output logic [COMMAND_BITS-1:0] o_command,
    output logic [BIT_IDX_W-1:0]    o_bits_decoded,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat
);

    logic [UNIT_W-1:0]    r_unit;
    logic [DUR_W-1:0]     r_hdr_mark;
    logic [DUR_W-1:0]     r_hdr_space;
    logic [TOL_W-1:0]     r_tol;
    logic [BIT_IDX_W-1:0] r_min_bits;

    logic [DUR_W-1:0] r_mark;
    logic [DUR_W-1:0] r_space;
    logic             r_end;

    logic              r_header_seen;
    logic [DCOUNT_W-1:0] r_dcount;
    logic [BIT_IDX_W-1:0] r_bit_index;
    logic [HALF_W-1:0] r_half;
    logic              r_first;
    logic              r_second;
    logic [FRAME_BITS-1:0] r_raw;
    t_status           r_frame_status;
    logic              r_stopped;

    logic [PROD_W-1:0] r_p_lo, r_p_hi, r_d100;
    logic              r_mark_ok;

    logic [UNIT_W-1:0] r_div;
    logic [UNIT_W:0]   r_rem;
    logic [NUM_W-1:0]  r_quot;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_level;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [ADDRESS_BITS-1:0] r_out_address;
    logic [COMMAND_BITS-1:0] r_out_command;
    logic [BIT_IDX_W-1:0]    r_out_bits;

    logic [TOL_W-1:0]  w_tol_cl;
    logic [TOL_W-1:0]  w_lo_f;
    logic [TOL_W:0]    w_hi_f;
    logic [DUR_W-1:0]  w_exp;
    logic [DUR_W-1:0]  w_dur;
    logic              w_hdr_ok;
    logic [UNIT_W-1:0] w_unit;
    logic [UNIT_W:0]   w_shift;
    logic [UNIT_W:0]   w_diff;
    logic              w_ge;
    logic              w_width2;
    logic              w_first;
    logic              w_second;
    logic [HALF_W-1:0] w_half_inc;
    logic              w_bit_end;
    logic [BIT_IDX_W-1:0] w_pos;
    logic [BIT_IDX_W-1:0] w_bit_inc;
    t_status           w_final;
    logic              w_out_free;

    assign w_tol_cl = (r_tol > TOL_W'(PCT_FULL)) ? TOL_W'(PCT_FULL) : r_tol;
    assign w_lo_f   = TOL_W'(PCT_FULL) - w_tol_cl;
    assign w_hi_f   = (TOL_W + 1)'(PCT_FULL) + {1'b0, w_tol_cl};
    assign w_exp    = i_cmd.sel ? r_hdr_space : r_hdr_mark;
    assign w_dur    = i_cmd.sel ? r_space : r_mark;
    assign w_hdr_ok = (r_p_lo <= r_d100 + PROD_W'(PCT_FULL - 1)) && (r_d100 <= r_p_hi);

    assign w_unit  = (r_unit == '0) ? UNIT_W'(1) : r_unit;
    assign w_shift = {r_rem[UNIT_W-1:0], r_quot[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    assign w_width2   = (r_bit_index == BIT_IDX_W'(TOGGLE_POSITION));
    assign w_first    = (r_half == '0) ? r_level : r_first;
    assign w_second   = (r_half == (w_width2 ? HALF_W'(2) : HALF_W'(1))) ? r_level : r_second;
    assign w_half_inc = r_half + HALF_W'(1);
    assign w_bit_end  = (w_half_inc == (w_width2 ? HALF_W'(4) : HALF_W'(2)));
    assign w_pos      = BIT_IDX_W'(FRAME_BITS - 1) - r_bit_index;
    assign w_bit_inc  = r_bit_index + BIT_IDX_W'(1);

    assign w_final = ((r_frame_status == ST_OK) && (r_bit_index < r_min_bits)) ? ST_FEW_BITS
                   : r_frame_status;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit         <= UNIT_W'(444);
            r_hdr_mark     <= DUR_W'(2666);
            r_hdr_space    <= DUR_W'(889);
            r_tol          <= TOL_W'(25);
            r_min_bits     <= BIT_IDX_W'(21);
            r_header_seen  <= 1'b0;
            r_dcount       <= '0;
            r_bit_index    <= '0;
            r_half         <= '0;
            r_first        <= 1'b0;
            r_second       <= 1'b0;
            r_raw          <= '0;
            r_frame_status <= ST_OK;
            r_stopped      <= 1'b0;
            r_dcnt         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_UNIT_LENGTH:  r_unit      <= i_cfg_data[UNIT_W-1:0];
                    CFG_HEADER_MARK:  r_hdr_mark  <= i_cfg_data[DUR_W-1:0];
                    CFG_HEADER_SPACE: r_hdr_space <= i_cfg_data[DUR_W-1:0];
                    CFG_TOLERANCE:    r_tol       <= i_cfg_data[TOL_W-1:0];
                    CFG_MIN_BITS:     r_min_bits  <= i_cfg_data[BIT_IDX_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.hcmp && i_cmd.sel) begin
                r_header_seen <= 1'b1;
                if (!(r_mark_ok && w_hdr_ok)) begin
                    r_frame_status <= ST_BAD_HEADER;
                    r_stopped      <= 1'b1;
                end
            end

            if (i_cmd.div_start) begin
                r_dcnt   <= DCNT_W'(NUM_W);
                r_dcount <= r_dcount + DCOUNT_W'(1);
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end

            if (i_cmd.unit_step) begin
                r_first  <= w_first;
                r_second <= w_second;
                if (!w_bit_end) begin
                    r_half <= w_half_inc;
                end else begin
                    r_half <= '0;
                    if (w_first != w_second) begin
                        if (w_first) begin
                            r_raw <= r_raw | (FRAME_BITS'(1) << w_pos);
                        end
                        r_bit_index <= w_bit_inc;
                        if (w_bit_inc >= BIT_IDX_W'(FRAME_BITS)) begin
                            r_stopped <= 1'b1;
                        end
                    end else begin
                        r_frame_status <= ST_BAD_BIPHASE;
                        r_stopped      <= 1'b1;
                    end
                end
            end

            if (i_cmd.emit) begin
                r_out_valid    <= 1'b1;
                r_header_seen  <= 1'b0;
                r_dcount       <= '0;
                r_bit_index    <= '0;
                r_half         <= '0;
                r_first        <= 1'b0;
                r_second       <= 1'b0;
                r_raw          <= '0;
                r_frame_status <= ST_OK;
                r_stopped      <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mark  <= i_mark_duration;
            r_space <= i_space_duration;
            r_end   <= i_frame_end;
        end
        if (i_cmd.hmul) begin
            r_p_lo <= PROD_W'(w_exp) * PROD_W'(w_lo_f);
            r_p_hi <= PROD_W'(w_exp) * PROD_W'(w_hi_f);
            r_d100 <= PROD_W'(w_dur) * PROD_W'(PCT_FULL);
        end
        if (i_cmd.hcmp && !i_cmd.sel) begin
            r_mark_ok <= w_hdr_ok;
        end
        if (i_cmd.div_start) begin
            r_div   <= w_unit;
            r_rem   <= '0;
            r_quot  <= NUM_W'(w_dur) + NUM_W'(w_unit >> 1);
            r_level <= ~r_dcount[0];
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff : w_shift;
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end else if (i_cmd.unit_step) begin
            r_quot <= r_quot - NUM_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_status  <= w_final;
            r_out_bits    <= r_bit_index;
            r_out_address <= (w_final == ST_OK) ? r_raw[ADDRESS_SHIFT +: ADDRESS_BITS] : '0;
            r_out_command <= (w_final == ST_OK) ? r_raw[COMMAND_BITS-1:0] : '0;
        end
    end

    assign o_stat.header_seen   = r_header_seen;
    assign o_stat.hdr_bad       = (r_frame_status == ST_BAD_HEADER);
    assign o_stat.list_full     = (r_dcount >= DCOUNT_W'(MAX_DURATIONS));
    assign o_stat.mark_nonzero  = (r_mark != '0);
    assign o_stat.space_nonzero = (r_space != '0);
    assign o_stat.div_done      = (r_dcnt == '0);
    assign o_stat.units_zero    = (r_quot == '0);
    assign o_stat.stopped       = r_stopped;
    assign o_stat.frame_end     = r_end;
    assign o_stat.out_free      = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_address      = r_out_address;
    assign o_command      = r_out_command;
    assign o_bits_decoded = r_out_bits;

endmodule

// ===== src/rc6_biphase_ir_decoder_unit.sv =====
// Leader symbol: accepted, then multiply and compare per header duration, then end check.
// Data symbol: accepted, then a pick per duration; a nonzero one adds a rounding divide,
//   a step per unit (up to 44 units per frame) and a unit exit; then an end step.
// Frame end adds a step to load the result register, held back while the previous result
//   waits unread; the next symbol is taken while the new result waits.
// Reset (synchronous, active low): registers back to defaults, frame state cleared.
`include "rc6_biphase_ir_decoder_unit_defines.svh"

module rc6_biphase_ir_decoder_unit
    import rc6bp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [DUR_W-1:0]        i_mark_duration,
    input  logic [DUR_W-1:0]        i_space_duration,
    input  logic                    i_frame_end,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [ADDRESS_BITS-1:0] o_address,
    output logic [COMMAND_BITS-1:0] o_command,
    output logic [BIT_IDX_W-1:0]    o_bits_decoded
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rc6bp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rc6bp_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mark_duration  (i_mark_duration),
        .i_space_duration (i_space_duration),
        .i_frame_end      (i_frame_end),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_address        (o_address),
        .o_command        (o_command),
        .o_bits_decoded   (o_bits_decoded),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat)
    );

    `RC6BP_ASSERT_IMPL(a_emit_free, w_cmd.emit, w_stat.out_free, "emit over pending result")
    `RC6BP_ASSERT_NEXT(a_emit_valid, w_cmd.emit, o_out_valid, "result not presented after emit")
    `RC6BP_ASSERT_IMPL(a_div_bound, w_cmd.div_step, !w_stat.div_done, "divider overrun")
    `RC6BP_ASSERT_IMPL(a_fields_zero, o_out_valid && (o_status != ST_OK),
                       {o_address, o_command} == '0, "fields nonzero on failed frame")

endmodule

// ===== tb/tb_rc6_biphase_ir_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_rc6_biphase_ir_decoder_unit;
    import rc6bp_pkg::*;

    localparam int unsigned DUR_MAX        = (1 << DUR_W) - 1;
    localparam int unsigned SETTLE_CYCLES  = 200;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned HOLD_AFTER     = 20;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned PHASE_ITEMS    = 125;
    localparam int unsigned PHASES         = 10;

    typedef struct packed {
        logic [DUR_W-1:0] mark;
        logic [DUR_W-1:0] space;
        logic             fend;
    } t_ir_symbol;

    typedef struct packed {
        t_status                 status;
        logic [ADDRESS_BITS-1:0] address;
        logic [COMMAND_BITS-1:0] command;
        logic [BIT_IDX_W-1:0]    bits;
    } t_frame_report;

    typedef enum {
        FK_GOOD,
        FK_SHORT,
        FK_LONG,
        FK_CORRUPT,
        FK_BAD_HEADER,
        FK_NOISE,
        FK_FLOOD
    } t_frame_kind;

    typedef enum {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE
    } t_ready_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    t_cfg_index              i_cfg_index = CFG_UNIT_LENGTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [DUR_W-1:0]        i_mark_duration = '0;
    logic [DUR_W-1:0]        i_space_duration = '0;
    logic                    i_frame_end = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [1:0]              o_status;
    logic [ADDRESS_BITS-1:0] o_address;
    logic [COMMAND_BITS-1:0] o_command;
    logic [BIT_IDX_W-1:0]    o_bits_decoded;

    rc6_biphase_ir_decoder_unit DUT (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    logic [UNIT_W-1:0]    cfg_unit_len;
    logic [DUR_W-1:0]     cfg_hdr_mark;
    logic [DUR_W-1:0]     cfg_hdr_space;
    logic [TOL_W-1:0]     cfg_tol;
    logic [BIT_IDX_W-1:0] cfg_min_bits;

    bit                   fr_header_seen;
    int unsigned          fr_dur_count;
    int unsigned          fr_bit_idx;
    int unsigned          fr_half_idx;
    bit                   fr_first_lvl;
    bit                   fr_second_lvl;
    logic [FRAME_BITS-1:0] fr_raw;
    t_status              fr_status;
    bit                   fr_stopped;

    t_ir_symbol    pending_symbols[$];
    t_frame_report expected_frames[$];
    int unsigned   symbols_queued = 0;
    int unsigned   symbols_accepted = 0;
    int unsigned   frames_checked = 0;
    int unsigned   errors = 0;

    t_ir_symbol    next_sym;
    t_frame_report want;
    logic          in_taken = 1'b0;
    int unsigned   burst_left = 1;
    int unsigned   gap_left = 0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    int unsigned   seg_left = 0;
    t_ready_mode   seg_mode = RDY_ALWAYS;
    int unsigned   idle_cycles = 0;

    function automatic void fr_clear();
        fr_header_seen = 1'b0;
        fr_dur_count   = 0;
        fr_bit_idx     = 0;
        fr_half_idx    = 0;
        fr_first_lvl   = 1'b0;
        fr_second_lvl  = 1'b0;
        fr_raw         = '0;
        fr_status      = ST_OK;
        fr_stopped     = 1'b0;
    endfunction

    function automatic void header_window(input int unsigned e, output int unsigned lo,
                                          output int unsigned hi);
        int unsigned t;
        t  = (cfg_tol > PCT_FULL) ? PCT_FULL : cfg_tol;
        lo = e * (PCT_FULL - t) / PCT_FULL;
        hi = e * (PCT_FULL + t) / PCT_FULL;
    endfunction

    function automatic bit header_match(int unsigned d, int unsigned e);
        int unsigned lo, hi;
        header_window(e, lo, hi);
        return (d >= lo) && (d <= hi);
    endfunction

    function automatic void fr_take_duration(int unsigned d);
        int unsigned u, units, w;
        bit          lvl;
        u     = (cfg_unit_len == 0) ? 1 : cfg_unit_len;
        units = (d + u / 2) / u;
        lvl   = (fr_dur_count % 2) == 0;
        fr_dur_count++;
        while (units > 0 && !fr_stopped) begin
            w = (fr_bit_idx == TOGGLE_POSITION) ? 2 : 1;
            if (fr_half_idx == 0) fr_first_lvl = lvl;
            if (fr_half_idx == w) fr_second_lvl = lvl;
            fr_half_idx++;
            if (fr_half_idx >= 2 * w) begin
                fr_half_idx = 0;
                if (fr_first_lvl && !fr_second_lvl) begin
                    fr_raw[FRAME_BITS - 1 - fr_bit_idx] = 1'b1;
                end else if (!(!fr_first_lvl && fr_second_lvl)) begin
                    fr_status  = ST_BAD_BIPHASE;
                    fr_stopped = 1'b1;
                end
                if (!fr_stopped) begin
                    fr_bit_idx++;
                    if (fr_bit_idx >= FRAME_BITS) fr_stopped = 1'b1;
                end
            end
            units--;
        end
    endfunction

    function automatic void ir_decode_symbol(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space,
                                             logic fend);
        t_frame_report rep;
        if (!fr_header_seen) begin
            fr_header_seen = 1'b1;
            if (!header_match(mark, cfg_hdr_mark) || !header_match(space, cfg_hdr_space)) begin
                fr_status  = ST_BAD_HEADER;
                fr_stopped = 1'b1;
            end
        end else if (fr_status != ST_BAD_HEADER && fr_dur_count < MAX_DURATIONS) begin
            if (mark != 0) fr_take_duration(mark);
            if (space != 0) fr_take_duration(space);
        end
        if (fend) begin
            rep.status  = fr_status;
            rep.address = '0;
            rep.command = '0;
            rep.bits    = BIT_IDX_W'(fr_bit_idx);
            if (fr_status == ST_OK && fr_bit_idx < cfg_min_bits) rep.status = ST_FEW_BITS;
            if (rep.status == ST_OK) begin
                rep.address = fr_raw[ADDRESS_SHIFT +: ADDRESS_BITS];
                rep.command = fr_raw[COMMAND_BITS-1:0];
            end
            expected_frames.push_back(rep);
            fr_clear();
        end
    endfunction

    function automatic void check_field(string fname, logic [15:0] exp_val, logic [15:0] got);
        if (got !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_val, got);
        end
    endfunction

    function automatic void push_symbol(int unsigned mark, int unsigned space, bit fend);
        t_ir_symbol s;
        s.mark  = DUR_W'(mark);
        s.space = DUR_W'(space);
        s.fend  = fend;
        pending_symbols.push_back(s);
        symbols_queued++;
    endfunction

    function automatic int unsigned pick_header_len(int unsigned e, bit good);
        int unsigned lo, hi;
        header_window(e, lo, hi);
        if (hi > DUR_MAX) hi = DUR_MAX;
        if (!good) begin
            if (lo > 0 && (hi == DUR_MAX || $urandom_range(0, 1))) return $urandom_range(0, lo - 1);
            if (hi < DUR_MAX) return $urandom_range(hi + 1, DUR_MAX);
        end
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic int unsigned unit_ticks(int unsigned n, int unsigned u);
        int unsigned d;
        d = n * u - u / 2 + $urandom_range(0, u - 1);
        return (d > DUR_MAX) ? DUR_MAX : d;
    endfunction

    function automatic void queue_frame(t_frame_kind kind, logic [FRAME_BITS-1:0] data);
        int unsigned runs[$];
        int unsigned fields[$];
        int unsigned u, tiny_max, w, lvl, last, i, h, k, cut;
        int unsigned hm, hs;
        bit          bad_m, bad_s;
        u        = (cfg_unit_len == 0) ? 1 : cfg_unit_len;
        tiny_max = (u + 1) / 2 - 1;
        bad_m    = (kind == FK_BAD_HEADER) && $urandom_range(0, 1);
        bad_s    = (kind == FK_BAD_HEADER) && (!bad_m || $urandom_range(0, 1));
        hm       = pick_header_len(cfg_hdr_mark, !bad_m);
        hs       = pick_header_len(cfg_hdr_space, !bad_s);
        if (kind == FK_NOISE) begin
            if ($urandom_range(0, 1)) begin
                hm = $urandom_range(0, DUR_MAX);
                hs = $urandom_range(0, DUR_MAX);
            end
            repeat (2 * $urandom_range(1, 8))
                fields.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, DUR_MAX));
        end else begin
            last = 2;
            for (i = 0; i < FRAME_BITS; i++) begin
                w = (i == TOGGLE_POSITION) ? 2 : 1;
                for (h = 0; h < 2 * w; h++) begin
                    lvl = (h < w) ? data[FRAME_BITS - 1 - i] : !data[FRAME_BITS - 1 - i];
                    if (lvl == last) begin
                        runs[runs.size() - 1] = runs[runs.size() - 1] + 1;
                    end else begin
                        runs.push_back(1);
                        last = lvl;
                    end
                end
            end
            case (kind)
                FK_SHORT: begin
                    cut = $urandom_range(0, runs.size() - 1);
                    while (runs.size() > cut) void'(runs.pop_back());
                end
                FK_LONG: repeat ($urandom_range(1, 6)) runs.push_back($urandom_range(1, 3));
                FK_CORRUPT: runs[$urandom_range(0, runs.size() - 1)] = $urandom_range(1, 4);
                default: ;
            endcase
            for (k = 0; k < runs.size(); k++) begin
                if (kind == FK_FLOOD || $urandom_range(0, 15) == 0) begin
                    fields.push_back((tiny_max == 0) ? 0 : $urandom_range(1, tiny_max));
                    fields.push_back((tiny_max == 0) ? 0 : $urandom_range(1, tiny_max));
                end
                if ($urandom_range(0, 9) == 0) fields.push_back(0);
                fields.push_back(unit_ticks(runs[k], u));
            end
        end
        if (fields.size() % 2) fields.push_back(0);
        push_symbol(hm, hs, fields.size() == 0);
        for (k = 0; k < fields.size(); k += 2)
            push_symbol(fields[k], fields[k + 1], k + 2 >= fields.size());
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_UNIT_LENGTH:  cfg_unit_len  = val[UNIT_W-1:0];
            CFG_HEADER_MARK:  cfg_hdr_mark  = val[DUR_W-1:0];
            CFG_HEADER_SPACE: cfg_hdr_space = val[DUR_W-1:0];
            CFG_TOLERANCE:    cfg_tol       = val[TOL_W-1:0];
            CFG_MIN_BITS:     cfg_min_bits  = val[BIT_IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned u, int unsigned hm, int unsigned hs,
                                  int unsigned tol, int unsigned minb);
        write_reg(CFG_UNIT_LENGTH, CFG_DATA_W'(u));
        write_reg(CFG_HEADER_MARK, CFG_DATA_W'(hm));
        write_reg(CFG_HEADER_SPACE, CFG_DATA_W'(hs));
        write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
        write_reg(CFG_MIN_BITS, CFG_DATA_W'(minb));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (symbols_accepted != symbols_queued || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_random(int unsigned n_items);
        int unsigned           start, r;
        t_frame_kind           kind;
        logic [FRAME_BITS-1:0] data;
        start = symbols_queued;
        while (symbols_queued - start < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 60)      kind = FK_GOOD;
            else if (r < 68) kind = FK_SHORT;
            else if (r < 76) kind = FK_LONG;
            else if (r < 84) kind = FK_CORRUPT;
            else if (r < 90) kind = FK_BAD_HEADER;
            else if (r < 96) kind = FK_NOISE;
            else             kind = FK_FLOOD;
            data = FRAME_BITS'($urandom);
            if ($urandom_range(0, 7) != 0) data[FRAME_BITS-1] = 1'b1;
            queue_frame(kind, data);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_symbols.size() != 0) begin
                next_sym = pending_symbols.pop_front();
                i_mark_duration  <= next_sym.mark;
                i_space_duration <= next_sym.space;
                i_frame_end      <= next_sym.fend;
                i_in_valid       <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && frames_checked >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left != 0) begin
                seg_left <= seg_left - 1;
            end else begin
                seg_left <= $urandom_range(8, 200);
                seg_mode <= t_ready_mode'($urandom_range(0, 2));
            end
            case (seg_mode)
                RDY_ALWAYS: i_out_ready <= 1'b1;
                RDY_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
                default:    i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            ir_decode_symbol(i_mark_duration, i_space_duration, i_frame_end);
            symbols_accepted++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame report, status %0d address %0d command %0d bits %0d",
                         $time, o_status, o_address, o_command, o_bits_decoded);
            end else begin
                want = expected_frames.pop_front();
                check_field("status", want.status, o_status);
                check_field("address", want.address, o_address);
                check_field("command", want.command, o_command);
                check_field("bits_decoded", want.bits, o_bits_decoded);
                frames_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned p;
        cfg_unit_len  = 444;
        cfg_hdr_mark  = 2666;
        cfg_hdr_space = 889;
        cfg_tol       = 25;
        cfg_min_bits  = 21;
        fr_clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_symbol(2666, 889, 1'b1);
        push_symbol(32767, 889, 1'b1);
        push_symbol(2666, 0, 1'b1);
        push_symbol(3333, 889, 1'b1);
        push_symbol(1999, 1111, 1'b0);
        push_symbol(888, 0, 1'b0);
        push_symbol(444, 444, 1'b1);
        push_symbol(3332, 666, 1'b0);
        push_symbol(444, 0, 1'b0);
        push_symbol(0, 0, 1'b1);
        queue_frame(FK_GOOD, 21'h10FF00);
        settle();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: ;
                1: apply_settings(1, 0, DUR_MAX, PCT_FULL, 0);
                2: apply_settings(4095, DUR_MAX, 0, 0, FRAME_BITS);
                3: apply_settings(0, $urandom_range(0, DUR_MAX), $urandom_range(0, DUR_MAX),
                                  127, 31);
                default: apply_settings($urandom_range(50, 1500), $urandom_range(0, DUR_MAX),
                                        $urandom_range(0, DUR_MAX), $urandom_range(0, PCT_FULL),
                                        $urandom_range(0, FRAME_BITS));
            endcase
            fill_random(PHASE_ITEMS);
            settle();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
